// ----- rtl/core/reed_solomon_parity_encoder_assert.svh -----
// Assertion macros used by the port checker of the parity encoder.
`ifndef REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH
`define REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define RSPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RSPE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rspe_pkg.sv -----
package rspe_pkg;

  localparam int unsigned MAX_PARITY = 30;
  localparam int unsigned CNT_W      = $clog2(MAX_PARITY + 1);

  localparam logic [4:0] ECC_RESET   = 5'd10;
  // Low byte of the field polynomial x^8+x^4+x^3+x^2+1
  localparam logic [7:0] GF_POLY_LOW = 8'h1D;

  typedef logic [MAX_PARITY-1:0][7:0] byte_vec_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef struct packed {
    logic start;
    cnt_t n;
  } gen_ctrl_t;

  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = gf_xtime(x);
    end
    return acc;
  endfunction

  // Saturate the programmed count to 1..MAX_PARITY
  function automatic cnt_t eff_count(input logic [4:0] ecc);
    if (ecc == 5'd0) return cnt_t'(1);
    if (32'(ecc) > MAX_PARITY) return cnt_t'(MAX_PARITY);
    return cnt_t'(ecc);
  endfunction

endpackage

// ----- rtl/core/rspe_gen_build.sv -----
// Builds the reversed generator polynomial prod (1 + alpha^i x), one root per
// cycle. coeff_o[i] is the coefficient of x^(i+1); the constant term 1 is implied.
// That ordering lines coeff_o[i] up with remainder tap i.
module rspe_gen_build (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rspe_pkg::gen_ctrl_t  ctrl_i,
  output rspe_pkg::byte_vec_t  coeff_o,
  output logic                 busy_o
);

  rspe_pkg::byte_vec_t coeff_q, coeff_d;
  logic [7:0]          root_q, root_d;
  rspe_pkg::cnt_t      iter_q, iter_d;

  assign busy_o  = (iter_q != ctrl_i.n);
  assign coeff_o = coeff_q;

  always_comb begin
    logic [7:0] prev;
    coeff_d = coeff_q;
    root_d  = root_q;
    iter_d  = iter_q;
    prev    = 8'h01;
    if (ctrl_i.start) begin
      coeff_d = '0;
      root_d  = 8'h01;
      iter_d  = '0;
    end else if (busy_o) begin
      // multiply by (1 + root x)
      for (int i = 0; i < rspe_pkg::MAX_PARITY; i++) begin
        coeff_d[i] = coeff_q[i] ^ rspe_pkg::gf_mul(root_q, prev);
        prev       = coeff_q[i];
      end
      root_d = rspe_pkg::gf_xtime(root_q);
      iter_d = iter_q + rspe_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
      root_q  <= 8'h01;
      iter_q  <= '0;
    end else begin
      coeff_q <= coeff_d;
      root_q  <= root_d;
      iter_q  <= iter_d;
    end
  end

endmodule

// ----- rtl/core/reed_solomon_parity_encoder.sv -----
// Systematic Reed-Solomon parity encoder over GF(2^8), polynomial 0x11D.
// Slave stream: one message byte per item, first byte highest order; tlast
// marks the last byte of a block. Master stream: the block's parity bytes,
// highest order first, tlast on the final one. cfg_we_i/cfg_wdata_i write the
// parity count (0 acts as 1, above 30 acts as 30) and clear the remainder.
// Throughput: one byte per cycle while s_axis_tready is high; each byte updates
// all remainder taps in the cycle it is accepted. The parity bytes appear in an
// output buffer in the cycle after the last byte is accepted and leave one per
// cycle as the sink takes them. A byte flagged last is held off until the previous
// block's parity has fully drained; ordinary bytes keep flowing meanwhile.
// After reset, and after every count write, the generator is rebuilt from its n
// roots (n = parity count, 10 after reset) with s_axis_tready low.
// A stalled sink holds the current parity byte and stops the buffer.
module reed_solomon_parity_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,   // ecc_count
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] parity_byte
  output logic       m_axis_tlast   // last_parity
);

  logic [4:0]          ecc_q;
  rspe_pkg::cnt_t      eff_n;
  rspe_pkg::gen_ctrl_t gen_ctrl;
  rspe_pkg::byte_vec_t coeff;
  logic                gen_busy;

  rspe_pkg::byte_vec_t rem_q, rem_d, rem_next;
  rspe_pkg::byte_vec_t obuf_q, obuf_d;
  rspe_pkg::cnt_t      ocnt_q, ocnt_d;
  logic [7:0]          factor;
  logic                in_fire, out_fire;

  assign eff_n          = rspe_pkg::eff_count(ecc_q);
  assign gen_ctrl.start = cfg_we_i;
  assign gen_ctrl.n     = eff_n;

  rspe_gen_build u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gen_ctrl),
    .coeff_o (coeff),
    .busy_o  (gen_busy)
  );

  assign s_axis_tready = !gen_busy && (!s_axis_tlast || (ocnt_q == '0));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (ocnt_q != '0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = obuf_q[0];
  assign m_axis_tlast  = (ocnt_q == rspe_pkg::cnt_t'(1));

  // Taps at or above n stay zero, so one uniform shift covers every count
  assign factor = s_axis_tdata ^ rem_q[0];
  always_comb begin
    for (int i = 0; i < rspe_pkg::MAX_PARITY - 1; i++) begin
      rem_next[i] = rem_q[i+1] ^ rspe_pkg::gf_mul(coeff[i], factor);
    end
    rem_next[rspe_pkg::MAX_PARITY-1] =
      rspe_pkg::gf_mul(coeff[rspe_pkg::MAX_PARITY-1], factor);
  end

  always_comb begin
    rem_d = rem_q;
    if (cfg_we_i) begin
      rem_d = '0;
    end else if (in_fire) begin
      rem_d = s_axis_tlast ? '0 : rem_next;
    end
  end

  always_comb begin
    obuf_d = obuf_q;
    ocnt_d = ocnt_q;
    if (in_fire && s_axis_tlast) begin
      obuf_d = rem_next;
      ocnt_d = eff_n;
    end else if (out_fire) begin
      // advance to the next parity byte
      for (int i = 0; i < rspe_pkg::MAX_PARITY - 1; i++) begin
        obuf_d[i] = obuf_q[i+1];
      end
      obuf_d[rspe_pkg::MAX_PARITY-1] = 8'h00;
      ocnt_d = ocnt_q - rspe_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecc_q  <= rspe_pkg::ECC_RESET;
      rem_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (cfg_we_i) ecc_q <= cfg_wdata_i;
      rem_q  <= rem_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

endmodule

// ----- rtl/core/rspe_port_check.sv -----
`include "reed_solomon_parity_encoder_assert.svh"

module rspe_port_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [4:0] cfg_wdata_i,   // ecc_count
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input logic       s_axis_tlast,  // last_byte
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,  // [7:0] parity_byte
  input logic       m_axis_tlast   // last_parity
);

  `RSPE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "parity item dropped or changed while stalled")
  `RSPE_ASSERT_NEXT(a_last_to_parity, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, m_axis_tvalid, "no parity after last byte")
  `RSPE_ASSERT_SAME(a_last_needs_empty, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, !m_axis_tvalid, "last byte taken while parity still pending")
  `RSPE_ASSERT_NEXT(a_cfg_rebuild, clk_i, rst_ni, cfg_we_i, !s_axis_tready, "input ready during generator rebuild")

endmodule

bind reed_solomon_parity_encoder rspe_port_check u_port_check (.*);
